// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion on a rising clock edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CSF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("semaphore check failed");

// Next-cycle implication, disabled while reset is held.
`define CSF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("semaphore check failed");

`endif

// ===== rtl/csf_pkg.sv =====
// Package for the counting semaphore with waiter queue: widths, codes,
// controller states and the command/status structs. No dependencies.
package csf_pkg;

  localparam int UNITS_W     = 20;
  localparam int AMT_W       = 16;
  localparam int ID_W        = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int GRANT_LIMIT = 16;
  localparam int GCNT_W      = 5;

  typedef logic [UNITS_W-1:0] units_t;
  typedef logic [AMT_W-1:0]   amt_t;
  typedef logic [ID_W-1:0]    ident_t;

  localparam units_t UNITS_MAX = '1;
  localparam units_t CAP_RESET = units_t'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_UNLIMITED = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    FN_ACQUIRE = 2'd0,
    FN_RELEASE = 2'd1,
    FN_FORCE   = 2'd2,
    FN_CANCEL  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_FORCED    = 3'd3,
    ST_CANCELLED = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6,
    ST_UNDERFLOW = 3'd7
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_REL_RD,
    S_REL_CHK,
    S_CAN_RD,
    S_CAN_CMP,
    S_SHF_RD,
    S_SHF_WR
  } state_t;

  typedef enum logic [1:0] {
    U_HOLD,
    U_ADD_ITEM,
    U_SUB_ITEM,
    U_ADD_HEAD
  } uop_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_IDX,
    RD_IDX1
  } rsel_t;

  typedef struct packed {
    logic  load_item;
    uop_t  uop;
    logic  push;
    logic  pop;
    logic  rel_start;
    logic  rd_en;
    rsel_t rsel;
    logic  idx_clr;
    logic  idx_inc;
    logic  shf_wr;
    logic  drop;
    logic  emit;
    logic  emit_pend;
    stat_t emit_st;
    logic  emit_last;
    logic  pend_grant;
  } csf_cmd_t;

  typedef struct packed {
    func_t func;
    logic  item_fits;
    logic  head_fits;
    logic  q_full;
    logic  q_empty;
    logic  idx_lt;
    logic  idx1_lt;
    logic  id_match;
    logic  limit_hit;
    logic  slot_free;
  } csf_stat_t;

  function automatic units_t add_sat(input units_t a, input amt_t b);
    logic [UNITS_W:0] s;
    s = {1'b0, a} + {{(UNITS_W + 1 - AMT_W){1'b0}}, b};
    return s[UNITS_W] ? UNITS_MAX : s[UNITS_W-1:0];
  endfunction

endpackage

// ===== rtl/csf_if.sv =====
// Channel interfaces of the semaphore: request, result and register write.
// Depends on nothing; widths follow the field widths of the block.
interface csf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] amount;
  logic [7:0]  requester;
  modport source (output valid, func, amount, requester, input ready);
  modport sink (input valid, func, amount, requester, output ready);
endinterface

interface csf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  grant_requester;
  logic [2:0]  status;
  logic [19:0] units_in_use;
  logic        last;
  modport source (output valid, grant_requester, status, units_in_use, last, input ready);
  modport sink (input valid, grant_requester, status, units_in_use, last, output ready);
endinterface

interface csf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/csf_ctrl.sv =====
// Controller state machine of the semaphore: sequences each request beat.
// Depends on csf_pkg; talks to csf_dpath through command and status structs.
module csf_ctrl
  import csf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  csf_stat_t st,
  output csf_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        unique case (st.func)
          FN_ACQUIRE, FN_FORCE: begin
            if (st.slot_free) state_nxt = S_IDLE;
          end
          FN_RELEASE: state_nxt = S_REL_RD;
          FN_CANCEL:  state_nxt = S_CAN_RD;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_REL_RD: begin
        if (!st.q_empty && !st.limit_hit) begin
          state_nxt = S_REL_CHK;
        end else if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_REL_CHK: begin
        if (st.slot_free) state_nxt = st.head_fits ? S_REL_RD : S_IDLE;
      end
      S_CAN_RD: begin
        if (st.idx_lt) begin
          state_nxt = S_CAN_CMP;
        end else if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_CAN_CMP: state_nxt = st.id_match ? S_SHF_RD : S_CAN_RD;
      S_SHF_RD: begin
        if (st.idx1_lt) begin
          state_nxt = S_SHF_WR;
        end else if (st.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHF_WR: state_nxt = S_SHF_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.load_item = in_valid;
      end
      S_DECIDE: begin
        unique case (st.func)
          FN_ACQUIRE: begin
            if (st.slot_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              if (st.item_fits) begin
                cmd.uop     = U_ADD_ITEM;
                cmd.emit_st = ST_GRANTED;
              end else if (!st.q_full) begin
                cmd.push    = 1'b1;
                cmd.emit_st = ST_QUEUED;
              end else begin
                cmd.emit_st = ST_FULL;
              end
            end
          end
          FN_FORCE: begin
            if (st.slot_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.uop       = U_ADD_ITEM;
              cmd.emit_st   = ST_FORCED;
            end
          end
          FN_RELEASE: begin
            cmd.uop       = U_SUB_ITEM;
            cmd.rel_start = 1'b1;
          end
          FN_CANCEL: cmd.idx_clr = 1'b1;
          default: ;
        endcase
      end
      S_REL_RD: begin
        if (!st.q_empty && !st.limit_hit) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RD_HEAD;
        end else if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_pend = 1'b1;
          cmd.emit_last = 1'b1;
        end
      end
      S_REL_CHK: begin
        if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_pend = 1'b1;
          if (st.head_fits) begin
            cmd.uop        = U_ADD_HEAD;
            cmd.pop        = 1'b1;
            cmd.pend_grant = 1'b1;
          end else begin
            cmd.emit_last = 1'b1;
          end
        end
      end
      S_CAN_RD: begin
        if (st.idx_lt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RD_IDX;
        end else if (st.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_st   = ST_NOT_FOUND;
          cmd.emit_last = 1'b1;
        end
      end
      S_CAN_CMP: begin
        cmd.idx_inc = !st.id_match;
      end
      S_SHF_RD: begin
        if (st.idx1_lt) begin
          cmd.rd_en = 1'b1;
          cmd.rsel  = RD_IDX1;
        end else if (st.slot_free) begin
          cmd.drop      = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_st   = ST_CANCELLED;
          cmd.emit_last = 1'b1;
        end
      end
      S_SHF_WR: begin
        cmd.shf_wr  = 1'b1;
        cmd.idx_inc = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/csf_dpath.sv =====
// Datapath of the semaphore: registers, unit counter, waiter queue memory
// and result register. Depends on csf_pkg; driven by csf_ctrl commands.
module csf_dpath
  import csf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           in_func,
  input  amt_t                 in_amount,
  input  ident_t               in_requester,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  units_t               cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ident_t               out_requester,
  output stat_t                out_status,
  output units_t               out_units,
  output logic                 out_last,
  input  csf_cmd_t             cmd,
  output csf_stat_t            st
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = IDX_W + 2;
  localparam int ENT_W = ID_W + AMT_W;

  typedef logic [IDX_W-1:0] qidx_t;
  typedef logic [CNT_W-1:0] qcnt_t;

  // Payload registers.
  func_t  item_func_r;
  amt_t   item_amt_r;
  ident_t item_req_r;
  ident_t pend_who_r;
  stat_t  pend_st_r;
  logic [ENT_W-1:0] rdata_r;
  logic [ENT_W-1:0] mem [QUEUE_DEPTH];

  // Control registers.
  units_t cap_r;
  logic   unl_r;
  units_t units_r;
  units_t units_nxt;
  qcnt_t  total_r;
  qidx_t  head_r;
  qcnt_t  idx_r;
  logic [GCNT_W-1:0] gcnt_r;

  logic   out_valid_r;
  ident_t out_who_r;
  stat_t  out_st_r;
  units_t out_units_r;
  logic   out_last_r;

  ident_t head_id;
  amt_t   head_amt;
  logic   under;
  qidx_t  addr_tail;
  qidx_t  addr_idx;
  qidx_t  addr_idx1;
  qidx_t  addr_rd;
  logic [CNT_W:0] idx1;

  function automatic qidx_t wrap(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(QUEUE_DEPTH)) begin
      wrap = IDX_W'(s - SUM_W'(QUEUE_DEPTH));
    end else begin
      wrap = IDX_W'(s);
    end
  endfunction

  assign head_id  = rdata_r[ENT_W-1:AMT_W];
  assign head_amt = rdata_r[AMT_W-1:0];
  assign under    = {{(UNITS_W - AMT_W){1'b0}}, item_amt_r} > units_r;
  assign idx1     = {1'b0, idx_r} + (CNT_W + 1)'(1);

  assign addr_tail = wrap(SUM_W'(head_r) + SUM_W'(total_r));
  assign addr_idx  = wrap(SUM_W'(head_r) + SUM_W'(idx_r));
  assign addr_idx1 = wrap(SUM_W'(head_r) + SUM_W'(idx1));

  always_comb begin
    case (cmd.rsel)
      RD_IDX:  addr_rd = addr_idx;
      RD_IDX1: addr_rd = addr_idx1;
      default: addr_rd = head_r;
    endcase
  end

  always_comb begin
    case (cmd.uop)
      U_ADD_ITEM: units_nxt = add_sat(units_r, item_amt_r);
      U_SUB_ITEM: units_nxt = under ? '0
                              : units_r - {{(UNITS_W - AMT_W){1'b0}}, item_amt_r};
      U_ADD_HEAD: units_nxt = add_sat(units_r, head_amt);
      default:    units_nxt = units_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    st.func      = item_func_r;
    st.item_fits = unl_r || (({1'b0, units_r} + (UNITS_W + 1)'(item_amt_r))
                             <= {1'b0, cap_r});
    st.head_fits = unl_r || (({1'b0, units_r} + (UNITS_W + 1)'(head_amt))
                             <= {1'b0, cap_r});
    st.q_full    = (total_r == CNT_W'(QUEUE_DEPTH));
    st.q_empty   = (total_r == '0);
    st.idx_lt    = (idx_r < total_r);
    st.idx1_lt   = (idx1 < {1'b0, total_r});
    st.id_match  = (head_id == item_req_r);
    st.limit_hit = (gcnt_r == GCNT_W'(GRANT_LIMIT));
    st.slot_free = !out_valid_r || out_ready;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
      unl_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPACITY:  cap_r <= cfg_data;
        CFG_UNLIMITED: unl_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Item and pending-result payload.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_func_r <= func_t'(in_func);
      item_amt_r  <= in_amount;
      item_req_r  <= in_requester;
    end
    if (cmd.rel_start) begin
      pend_who_r <= item_req_r;
      pend_st_r  <= under ? ST_UNDERFLOW : ST_RELEASED;
    end else if (cmd.pend_grant) begin
      pend_who_r <= head_id;
      pend_st_r  <= ST_GRANTED;
    end
  end

  // Counters and queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      units_r <= '0;
      total_r <= '0;
      head_r  <= '0;
      idx_r   <= '0;
      gcnt_r  <= '0;
    end else begin
      units_r <= units_nxt;
      if (cmd.push) begin
        total_r <= total_r + CNT_W'(1);
      end else if (cmd.pop || cmd.drop) begin
        total_r <= total_r - CNT_W'(1);
      end
      if (cmd.pop) head_r <= wrap(SUM_W'(head_r) + SUM_W'(1));
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (cmd.rel_start) begin
        gcnt_r <= '0;
      end else if (cmd.pop) begin
        gcnt_r <= gcnt_r + GCNT_W'(1);
      end
    end
  end

  // Waiter queue memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[addr_tail] <= {item_req_r, item_amt_r};
    end else if (cmd.shf_wr) begin
      mem[addr_idx] <= rdata_r;
    end
    if (cmd.rd_en) rdata_r <= mem[addr_rd];
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_who_r   <= cmd.emit_pend ? pend_who_r : item_req_r;
      out_st_r    <= cmd.emit_pend ? pend_st_r : cmd.emit_st;
      out_units_r <= cmd.emit_pend ? units_r : units_nxt;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_requester = out_who_r;
  assign out_status    = out_st_r;
  assign out_units     = out_units_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/counting_semaphore_fifo_top.sv =====
// Counting semaphore with a FIFO of waiters. An acquire or forced acquire shows its
// result beat through the result register once decided; a new request is taken only when idle.
// A release grants head waiters in order while they fit, up to GRANT_LIMIT; a cancel searches
// the queue entry by entry and moves later entries down, each read through the single read port
// of the queue memory. A result waiting on out_ready stalls the block. Reset (rst_n, synchronous,
// low) empties the queue and clears the unit count at once; no clearing pass.
module counting_semaphore_fifo_top
  import csf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst_n,
  csf_in_if.sink    in_ch,
  csf_out_if.source out_ch,
  csf_cfg_if.sink   cfg_ch
);

  // Command and status bundles between the controller and the datapath.
  csf_cmd_t  cmd;
  csf_stat_t st;
  stat_t     out_status;

  // Register writes are always taken; the user must send them only while idle (not enforced).
  assign cfg_ch.ready = 1'b1;

  // The controller owns sequencing: one request at a time, with a release
  // walking the head of the queue and a cancel sweeping it entry by entry.
  csf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the unit count, the configuration, the waiter queue
  // as a circular buffer in memory, and the result register. The result
  // register lets a new request beat in while an earlier result still waits.
  csf_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_ch.func),
    .in_amount     (in_ch.amount),
    .in_requester  (in_ch.requester),
    .cfg_valid     (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_requester (out_ch.grant_requester),
    .out_status    (out_status),
    .out_units     (out_ch.units_in_use),
    .out_last      (out_ch.last),
    .cmd           (cmd),
    .st            (st)
  );

  assign out_ch.status = out_status;

endmodule

// ===== rtl/csf_checker.sv =====
// Port-level checker for the semaphore top level, bound into it below.
// Depends on csf_pkg and the macros in assert_macros.svh.
`include "assert_macros.svh"

module csf_checker
  import csf_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [2:0]   out_status,
  input logic [19:0]  out_units,
  input logic         out_last
);

  // A result beat is held until it is taken.
  `CSF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Requests are handled one at a time: no new beat right after one is taken.
  `CSF_ASSERT_NXT(a_in_gap, clk, rst_n, in_valid && in_ready, !in_ready)

  // An underflowing release always reports an empty pool in its result beat.
  `CSF_ASSERT_IMP(a_under_zero, clk, rst_n, out_valid && out_status == ST_UNDERFLOW, out_units == '0)

  // Only a release can be followed by grants; every other answer is final.
  `CSF_ASSERT_IMP(a_single_last, clk, rst_n, out_valid && (out_status == ST_QUEUED || out_status == ST_FORCED || out_status == ST_CANCELLED || out_status == ST_NOT_FOUND || out_status == ST_FULL), out_last)

endmodule

bind counting_semaphore_fifo_top csf_checker u_csf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_units  (out_ch.units_in_use),
  .out_last   (out_ch.last)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for counting_semaphore_fifo_top: requests, register writes and
// result checking against a ledger that tracks units, waiters and pending answers.
// Depends on csf_pkg (rtl/csf_pkg.sv) and the channel interfaces (rtl/csf_if.sv).
import csf_pkg::*;

// Tracks what the semaphore should hold and the answers it still owes, in order.
class semaphore_ledger;
  typedef struct {
    ident_t who;
    amt_t   amt;
  } waiter_t;

  typedef struct {
    ident_t who;
    stat_t  st;
    units_t units;
    logic   last;
  } answer_t;

  int unsigned depth;
  units_t      capacity;
  logic        unlimited;
  units_t      held;
  waiter_t     waiters[$];
  answer_t     answers[$];
  int unsigned failures;

  function new(int unsigned queue_depth);
    depth     = queue_depth;
    capacity  = CAP_RESET;
    unlimited = 1'b0;
    held      = '0;
    failures  = 0;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [UNITS_W-1:0] data);
    if (idx == CFG_CAPACITY) begin
      capacity = data;
    end else if (idx == CFG_UNLIMITED) begin
      unlimited = data[0];
    end
  endfunction

  function units_t sum_clamped(units_t base, amt_t add);
    logic [UNITS_W:0] total;
    total = {1'b0, base} + (UNITS_W + 1)'(add);
    return total[UNITS_W] ? UNITS_MAX : total[UNITS_W-1:0];
  endfunction

  function bit room_for(amt_t a);
    return unlimited || ((UNITS_W + 1)'(held) + (UNITS_W + 1)'(a) <= (UNITS_W + 1)'(capacity));
  endfunction

  function void post(ident_t who, stat_t st);
    answers.insert(answers.size(), answer_t'{who, st, held, 1'b1});
  endfunction

  function void take_request(func_t f, amt_t a, ident_t who);
    int unsigned grants;
    int          hit;
    grants = 0;
    hit    = -1;
    case (f)
      FN_ACQUIRE: begin
        if (room_for(a)) begin
          held = sum_clamped(held, a);
          post(who, ST_GRANTED);
        end else if (waiters.size() < depth) begin
          waiters.insert(waiters.size(), waiter_t'{who, a});
          post(who, ST_QUEUED);
        end else begin
          post(who, ST_FULL);
        end
      end
      FN_FORCE: begin
        held = sum_clamped(held, a);
        post(who, ST_FORCED);
      end
      FN_CANCEL: begin
        foreach (waiters[i]) begin
          if (hit < 0 && waiters[i].who == who) hit = i;
        end
        if (hit >= 0) begin
          waiters.delete(hit);
          post(who, ST_CANCELLED);
        end else begin
          post(who, ST_NOT_FOUND);
        end
      end
      FN_RELEASE: begin
        if (a > held) begin
          held = '0;
          post(who, ST_UNDERFLOW);
        end else begin
          held = held - a;
          post(who, ST_RELEASED);
        end
        // Head waiters are granted in order while they fit; the previous answer
        // of this request loses its last flag each time another one follows.
        while (grants < GRANT_LIMIT && waiters.size() > 0 && room_for(waiters[0].amt)) begin
          held = sum_clamped(held, waiters[0].amt);
          answers[answers.size() - 1].last = 1'b0;
          post(waiters[0].who, ST_GRANTED);
          void'(waiters.pop_front());
          grants++;
        end
      end
    endcase
  endfunction

  function void field_check(string field, logic [UNITS_W-1:0] want, logic [UNITS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  function void match_answer(logic [ID_W-1:0] who, logic [2:0] st, logic [UNITS_W-1:0] units,
                             logic last);
    answer_t want;
    if (answers.size() == 0) begin
      $error("result beat with nothing pending: requester %0d status %0d", who, st);
      failures++;
      return;
    end
    want = answers.pop_front();
    field_check("grant_requester", UNITS_W'(want.who), UNITS_W'(who));
    field_check("status", UNITS_W'(want.st), UNITS_W'(st));
    field_check("units_in_use", want.units, units);
    field_check("last", UNITS_W'(want.last), UNITS_W'(last));
  endfunction

  function int unsigned outstanding();
    return answers.size();
  endfunction
endclass

module testbench;
  localparam int QDEPTH = 16;
  // The block is idle once its last answer is out; this is only a margin of
  // quiet cycles before register writes.
  localparam int DRAIN_CYCLES = 80;
  // Register indexes that the block does not implement; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

  logic clk;
  logic rst_n;

  csf_in_if  in_if ();
  csf_out_if out_if ();
  csf_cfg_if cfg_if ();

  counting_semaphore_fifo_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  semaphore_ledger ledger = new(QDEPTH);

  // When set, the matching side stops inserting random idle cycles for a while.
  bit send_calm;
  bit take_calm;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run must never take anywhere near this long; if it does, something hangs.
  initial begin : watchdog
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: before each beat it stalls a random number of cycles, then holds
  // ready high until the block presents a beat, which is checked at that edge.
  initial begin : answer_sink
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = take_calm ? 0 : $urandom_range(0, 8);
      @(negedge clk);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      ledger.match_answer(out_if.grant_requester, out_if.status, out_if.units_in_use,
                          out_if.last);
    end
  end

  // Presents one request after a random gap and waits until the block takes it.
  // Valid stays high when the next request follows without a gap.
  task automatic send_request(func_t f, amt_t a, ident_t who);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.func      = f;
    in_if.amount    = a;
    in_if.requester = who;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    ledger.take_request(f, a, who);
  endtask

  // Register writes happen only while the block is idle, after settle().
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [UNITS_W-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    ledger.write_register(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Stops sending, waits for every owed answer, then leaves a margin of quiet cycles.
  task automatic settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly a small pool of clients so that cancels find their waiters, with
  // the occasional identifier from the full range.
  function automatic ident_t pick_client();
    return ($urandom_range(0, 3) == 0) ? ident_t'($urandom) : ident_t'($urandom_range(0, 7));
  endfunction

  // Heavy amounts push the count toward saturation and keep waiters from fitting.
  function automatic amt_t pick_amount(bit heavy);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return heavy ? amt_t'($urandom_range(40000, 65535)) : amt_t'($urandom);
  endfunction

  // Random requests with the given mix in percent; whatever is left over is cancels.
  task automatic run_mix(int unsigned count, int unsigned acq_pct, int unsigned rel_pct,
                         int unsigned force_pct, bit heavy);
    int unsigned pick;
    int unsigned ceiling;
    func_t       f;
    amt_t        a;
    ident_t      who;
    for (int unsigned n = 0; n < count; n++) begin
      // Every so often, switch each side between random gaps and running flat out.
      if (n % 20 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
        take_calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      who  = pick_client();
      if (pick < acq_pct) begin
        f = FN_ACQUIRE;
        a = pick_amount(heavy);
      end else if (pick < acq_pct + rel_pct) begin
        // Releases mostly return what is really held; a few overshoot and underflow.
        f       = FN_RELEASE;
        ceiling = (ledger.held > 65535) ? 65535 : ledger.held;
        a = ($urandom_range(0, 9) == 0) ? amt_t'($urandom) : amt_t'($urandom_range(0, ceiling));
      end else if (pick < acq_pct + rel_pct + force_pct) begin
        f = FN_FORCE;
        a = pick_amount(heavy);
      end else begin
        f = FN_CANCEL;
        a = amt_t'($urandom);
        if (ledger.waiters.size() > 0 && $urandom_range(0, 3) != 0) begin
          who = ledger.waiters[$urandom_range(0, ledger.waiters.size() - 1)].who;
        end
      end
      send_request(f, a, who);
    end
  endtask

  initial begin : stimulus
    int unsigned guard;
    in_if.valid     = 1'b0;
    in_if.func      = FN_ACQUIRE;
    in_if.amount    = '0;
    in_if.requester = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_CAPACITY;
    cfg_if.data     = '0;
    send_calm       = 1'b0;
    take_calm       = 1'b0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // At the reset capacity of one unit: one grant, one waiter, and a release
    // that hands the freed unit straight to that waiter.
    send_request(FN_ACQUIRE, 16'd1, 8'd0);
    send_request(FN_ACQUIRE, 16'd1, 8'd1);
    send_request(FN_RELEASE, 16'd1, 8'd0);
    send_request(FN_RELEASE, 16'd1, 8'd1);
    settle();

    // Hand-picked sequence at a capacity of 100. A request that fits is granted
    // even with others waiting; a cancel of an unknown client reports not found;
    // a release grants head waiters until one does not fit; an oversized release
    // clamps to zero and reports underflow; zero amounts behave like any other.
    write_register(CFG_CAPACITY, 20'd100);
    send_request(FN_ACQUIRE, 16'd0, 8'h00);
    send_request(FN_ACQUIRE, 16'd60, 8'd1);
    send_request(FN_ACQUIRE, 16'd50, 8'd2);
    send_request(FN_ACQUIRE, 16'd40, 8'd3);
    send_request(FN_ACQUIRE, 16'd1, 8'hFF);
    send_request(FN_CANCEL, 16'hFFFF, 8'hAA);
    send_request(FN_CANCEL, 16'd0, 8'd2);
    send_request(FN_ACQUIRE, 16'd30, 8'd4);
    send_request(FN_ACQUIRE, 16'd30, 8'd5);
    send_request(FN_RELEASE, 16'd60, 8'd1);
    send_request(FN_RELEASE, 16'hFFFF, 8'd3);
    send_request(FN_FORCE, 16'hFFFF, 8'h80);
    send_request(FN_RELEASE, 16'd0, 8'd7);
    send_request(FN_FORCE, 16'd0, 8'd6);
    send_request(FN_CANCEL, 16'd0, 8'hFF);
    settle();

    // With no capacity at all, acquires pile up until the queue is full and the
    // rest are turned away. Raising the capacity grants nobody by itself; the
    // zero release that follows then grants the whole queue in one go.
    write_register(CFG_CAPACITY, '0);
    run_mix(20, 100, 0, 0, 1'b0);
    settle();
    write_register(CFG_CAPACITY, UNITS_MAX);
    send_request(FN_RELEASE, 16'd0, pick_client());
    run_mix(30, 40, 30, 10, 1'b0);
    settle();

    // Waiters under unlimited mode: fill the queue with no capacity, switch to
    // unlimited and release; every waiter is granted although none fits. Heavy
    // acquires and forced acquires then drive the count into saturation.
    write_register(CFG_CAPACITY, '0);
    run_mix(18, 100, 0, 0, 1'b1);
    settle();
    write_register(CFG_UNLIMITED, {19'($urandom), 1'b1});
    send_request(FN_RELEASE, 16'd0, pick_client());
    run_mix(35, 45, 10, 40, 1'b1);
    settle();

    // Writes to unimplemented indexes change nothing. Unlimited mode is cleared
    // with the other data bits set at random, and the count is brought back
    // down by large releases, the last one underflowing.
    write_register(CFG_SPARE_LO, 20'($urandom));
    write_register(CFG_SPARE_HI, 20'($urandom));
    write_register(CFG_UNLIMITED, {19'($urandom), 1'b0});
    write_register(CFG_CAPACITY, 20'd200000);
    guard = 0;
    while (ledger.held > 0 && guard < 40) begin
      send_request(FN_RELEASE, 16'hFFFF, pick_client());
      guard++;
    end
    run_mix(50, 45, 30, 10, 1'b0);
    settle();

    // A random middle capacity so that waiters come and go often.
    write_register(CFG_CAPACITY, 20'($urandom_range(20000, 150000)));
    run_mix(40, 40, 35, 10, 1'b0);
    settle();

    if (ledger.failures == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
